### rtl/core/mcpwm_pkg.sv
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared types and constants of the multi-channel PWM generator.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

	localparam int DATA_W     = 32;
	localparam int WAVE_W     = 4;
	localparam int CHAN_SEL_W = 2;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [WAVE_W-1:0] wave_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	localparam logic REG_HIGH   = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

endpackage

### rtl/core/multi_channel_pwm_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator
// Multi-channel PWM with pending (shadow) high-time and period registers.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while input is open: a tick, a register
// write or a register read. Every accepted transaction returns one result,
// held in the result or the skid register, with the read value (zero unless
// a read) and the channel levels from before the transaction. The counters
// of all channels advance together on each tick, so a tick may arrive on
// every clock while input is open. The output side has a result register
// and a skid register, so input stays open for one more transaction while
// a result waits; a second waiting result closes input until the first is
// taken. All channel registers reset to zero: channels start stopped with
// their outputs high, and load their pending values on the first tick.
module multi_channel_pwm_generator #(
	parameter int CHANNELS    = 4,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            action,
	input  logic [mcpwm_pkg::CHAN_SEL_W-1:0]      channel,
	input  logic                                  reg_select,
	input  mcpwm_pkg::data_t                      write_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mcpwm_pkg::data_t                      read_data,
	output mcpwm_pkg::wave_t                      wave_out
);
	import mcpwm_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	count_t pending_period_q [CHANNELS];
	count_t pending_high_q   [CHANNELS];
	count_t active_period_q  [CHANNELS];
	count_t active_high_q    [CHANNELS];
	count_t phase_q          [CHANNELS];

	logic [CHANNELS-1:0] level;
	action_t             act;
	logic                ch_ok;
	logic [IDX_W-1:0]    idx;
	count_t              wdata;
	data_t               res_read;
	wave_t               res_wave;
	logic                in_fire;
	logic                out_fire;
	logic                out_valid_q;
	logic                skid_valid_q;
	data_t               out_read_q;
	wave_t               out_wave_q;
	data_t               skid_read_q;
	wave_t               skid_wave_q;

	assign act      = action_t'(action);
	assign ch_ok    = (32'(channel) < CHANNELS);
	assign idx      = IDX_W'(channel);
	assign wdata    = write_data[COUNT_WIDTH-1:0];
	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			level[c] = (active_period_q[c] == '0) || (phase_q[c] < active_high_q[c]);
		end
	end

	always_comb begin
		res_wave = WAVE_W'(level);
		res_read = '0;
		if (act == ACT_READ && ch_ok) begin
			if (reg_select == REG_PERIOD) begin
				res_read = DATA_W'(pending_period_q[idx]);
			end else begin
				res_read = DATA_W'(pending_high_q[idx]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pending_period_q[c] <= '0;
				pending_high_q[c]   <= '0;
				active_period_q[c]  <= '0;
				active_high_q[c]    <= '0;
				phase_q[c]          <= '0;
			end
		end else if (in_fire) begin
			case (act)
				ACT_TICK: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (active_period_q[c] == '0 ||
						    ({1'b0, phase_q[c]} + 1'b1) >= {1'b0, active_period_q[c]}) begin
							active_period_q[c] <= pending_period_q[c];
							active_high_q[c]   <= pending_high_q[c];
							phase_q[c]         <= '0;
						end else begin
							phase_q[c] <= phase_q[c] + 1'b1;
						end
					end
				end
				ACT_WRITE: begin
					if (ch_ok) begin
						if (reg_select == REG_PERIOD) begin
							pending_period_q[idx] <= wdata;
						end else begin
							pending_high_q[idx] <= wdata;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_fire) begin
				if (out_valid_q && !out_ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_read_q <= skid_read_q;
				out_wave_q <= skid_wave_q;
			end
		end else if (in_fire) begin
			if (out_valid_q && !out_ready) begin
				skid_read_q <= res_read;
				skid_wave_q <= res_wave;
			end else begin
				out_read_q <= res_read;
				out_wave_q <= res_wave;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_read_q;
	assign wave_out  = out_wave_q;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while result register empty");

	a_phase_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		(active_period_q[0] != '0) |-> (phase_q[0] < active_period_q[0]))
		else $error("phase count reached active period");

	a_write_period: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && act == ACT_WRITE && reg_select == REG_PERIOD && channel == '0)
		|=> (pending_period_q[0] == $past(write_data[COUNT_WIDTH-1:0])))
		else $error("period write not stored");

	a_fall_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without being taken");
`endif

endmodule

### sim/tb_multi_channel_pwm_generator.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_pwm_generator
// Self-checking regression of the four-channel PWM generator.
// ----------------------------------------------------------------------------
// A queue of transactions (ticks, register writes, register reads and the
// unused action code) feeds a clocked driver. Each accepted transaction runs
// through a cycle-free model of the shadow and live registers and the phase
// counters, and the predicted read data and channel levels are compared with
// every result that the monitor takes. Both sides idle at random, the
// receiver holds off once for a long stretch, and the sender now and then
// waits for all outstanding results before it goes on.
module tb_multi_channel_pwm_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import mcpwm_pkg::*;

	localparam int         NUM_CHAN   = 4;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         ITEM_COUNT = 425;
	localparam int         HOLD_OFF   = 60;

	typedef struct {
		logic [1:0] action;
		logic [1:0] channel;
		logic       reg_select;
		data_t      write_data;
		int         gap;
		bit         drain;
	} pwm_txn_t;

	typedef struct {
		data_t read_data;
		wave_t wave;
	} pwm_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] action = ACT_TICK;
	logic [1:0] channel = '0;
	logic       reg_select = REG_HIGH;
	data_t      write_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	data_t      read_data;
	wave_t      wave_out;

	pwm_txn_t    txn_q[$];
	pwm_result_t expected_q[$];
	pwm_txn_t    cur_txn;
	pwm_txn_t    nxt_txn;
	pwm_result_t got_result;
	pwm_result_t want_result;

	data_t shadow_high[NUM_CHAN];
	data_t shadow_period[NUM_CHAN];
	data_t live_high[NUM_CHAN];
	data_t live_period[NUM_CHAN];
	data_t phase[NUM_CHAN];

	int  send_wait = 0;
	int  rx_wait = 0;
	bit  rx_calm = 1'b0;
	bit  tx_calm = 1'b0;
	bit  hold_off = 1'b0;
	int  queued_items = 0;
	int  sent_count = 0;
	int  results_seen = 0;
	int  mismatches = 0;
	int  tick_count = 0;
	int  write_count = 0;
	int  read_count = 0;
	int  unused_count = 0;
	int  in_stall_cycles = 0;

	multi_channel_pwm_generator #(
		.CHANNELS   (NUM_CHAN),
		.COUNT_WIDTH(DATA_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.channel   (channel),
		.reg_select(reg_select),
		.write_data(write_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.wave_out  (wave_out)
	);

	always #5 clk = ~clk;

	function automatic pwm_result_t predict_pwm(input pwm_txn_t t);
		pwm_result_t r;
		data_t       next_phase;
		r.read_data = '0;
		r.wave = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			r.wave[c] = (live_period[c] == '0) || (phase[c] < live_high[c]);
		end
		if (t.action == ACT_TICK) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				next_phase = phase[c] + 1;
				if (live_period[c] == '0 || next_phase >= live_period[c]) begin
					live_period[c] = shadow_period[c];
					live_high[c] = shadow_high[c];
					phase[c] = '0;
				end else begin
					phase[c] = next_phase;
				end
			end
		end else if (t.action == ACT_WRITE) begin
			if (t.reg_select == REG_PERIOD)
				shadow_period[t.channel] = t.write_data;
			else
				shadow_high[t.channel] = t.write_data;
		end else if (t.action == ACT_READ) begin
			r.read_data = (t.reg_select == REG_PERIOD) ? shadow_period[t.channel]
				: shadow_high[t.channel];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input data_t got, input data_t want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
	endtask

	task automatic queue_txn(input logic [1:0] act, input logic [1:0] ch, input logic sel,
			input data_t data);
		pwm_txn_t t;
		t.action = act;
		t.channel = ch;
		t.reg_select = sel;
		t.write_data = data;
		t.gap = tx_calm ? 0 : $urandom_range(0, 10);
		t.drain = 1'b0;
		txn_q.push_back(t);
		queued_items++;
		if (queued_items % 40 == 0)
			tx_calm = !tx_calm;
	endtask

	task automatic queue_drain();
		pwm_txn_t t;
		t.action = ACT_TICK;
		t.channel = '0;
		t.reg_select = REG_HIGH;
		t.write_data = '0;
		t.gap = 0;
		t.drain = 1'b1;
		txn_q.push_back(t);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_TICK;
			channel <= '0;
			reg_select <= REG_HIGH;
			write_data <= '0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_q.push_back(predict_pwm(cur_txn));
				sent_count++;
				if (cur_txn.action == ACT_TICK)
					tick_count++;
				else if (cur_txn.action == ACT_WRITE)
					write_count++;
				else if (cur_txn.action == ACT_READ)
					read_count++;
				else
					unused_count++;
			end
			if (!in_valid || in_ready) begin
				if (txn_q.size() > 0 && txn_q[0].drain && expected_q.size() == 0)
					void'(txn_q.pop_front());
				if (send_wait > 0 || txn_q.size() == 0 || txn_q[0].drain) begin
					if (send_wait > 0)
						send_wait--;
					in_valid <= 1'b0;
				end else begin
					nxt_txn = txn_q.pop_front();
					cur_txn = nxt_txn;
					send_wait = nxt_txn.gap;
					in_valid <= 1'b1;
					action <= nxt_txn.action;
					channel <= nxt_txn.channel;
					reg_select <= nxt_txn.reg_select;
					write_data <= nxt_txn.write_data;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (in_valid && !in_ready)
				in_stall_cycles++;
			if (out_valid && out_ready) begin
				got_result.read_data = read_data;
				got_result.wave = wave_out;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result read_data", got_result.read_data, '0);
				end else begin
					want_result = expected_q.pop_front();
					if (got_result.read_data !== want_result.read_data)
						report_mismatch("read_data", got_result.read_data,
							want_result.read_data);
					if (got_result.wave !== want_result.wave)
						report_mismatch("wave_out", data_t'(got_result.wave),
							data_t'(want_result.wave));
				end
				results_seen++;
				if (results_seen % 64 == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off
	initial begin
		while (sent_count < 200)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2000000;
		$display("multi_channel_pwm_generator regression: fail");
		$finish;
	end

	initial begin
		int    kind;
		int    run;
		data_t big;
		logic [1:0] ch;

		for (int c = 0; c < NUM_CHAN; c++) begin
			shadow_high[c] = '0;
			shadow_period[c] = '0;
			live_high[c] = '0;
			live_period[c] = '0;
			phase[c] = '0;
		end

		queue_txn(ACT_TICK, 2'd0, REG_HIGH, 32'd0);
		queue_txn(ACT_READ, 2'd0, REG_HIGH, 32'd0);
		queue_txn(ACT_READ, 2'd3, REG_PERIOD, 32'd0);
		queue_txn(ACT_WRITE, 2'd0, REG_HIGH, 32'hFFFF_FFFF);
		queue_txn(ACT_READ, 2'd0, REG_HIGH, 32'd0);
		queue_txn(ACT_WRITE, 2'd0, REG_PERIOD, 32'hFFFF_FFFF);
		queue_txn(ACT_READ, 2'd0, REG_PERIOD, 32'hFFFF_FFFF);
		queue_txn(ACT_WRITE, 2'd0, REG_PERIOD, 32'd4);
		queue_txn(ACT_WRITE, 2'd1, REG_HIGH, 32'd2);
		queue_txn(ACT_WRITE, 2'd1, REG_PERIOD, 32'd5);
		queue_txn(ACT_WRITE, 2'd2, REG_HIGH, 32'd0);
		queue_txn(ACT_WRITE, 2'd2, REG_PERIOD, 32'd3);
		queue_txn(ACT_WRITE, 2'd3, REG_HIGH, 32'd7);
		queue_txn(ACT_WRITE, 2'd3, REG_PERIOD, 32'd3);
		queue_txn(ACT_UNUSED, 2'd3, REG_PERIOD, 32'hA5A5_5A5A);
		queue_txn(ACT_READ, 2'd3, REG_PERIOD, 32'd0);
		repeat (6) queue_txn(ACT_TICK, 2'd0, REG_HIGH, 32'd0);
		queue_txn(ACT_WRITE, 2'd2, REG_PERIOD, 32'd0);
		repeat (2) queue_txn(ACT_TICK, 2'd0, REG_HIGH, 32'd0);
		queue_drain();

		while (queued_items < ITEM_COUNT) begin
			kind = $urandom_range(0, 99);
			ch = 2'($urandom_range(0, 3));
			if (kind < 50) begin
				run = $urandom_range(1, 8);
				repeat (run) queue_txn(ACT_TICK, 2'($urandom), 1'($urandom), $urandom);
			end else if (kind < 75) begin
				queue_txn(ACT_WRITE, ch, 1'($urandom), $urandom_range(0, 12));
			end else if (kind < 85) begin
				queue_txn(ACT_READ, ch, 1'($urandom), $urandom);
			end else if (kind < 90) begin
				big = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
				queue_txn(ACT_WRITE, ch, REG_HIGH, big);
			end else if (kind < 94) begin
				big = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
				queue_txn(ACT_WRITE, ch, REG_PERIOD, big);
				queue_txn(ACT_READ, ch, REG_PERIOD, 32'd0);
				queue_txn(ACT_WRITE, ch, REG_PERIOD, $urandom_range(1, 12));
			end else if (kind < 97) begin
				queue_txn(ACT_UNUSED, ch, 1'($urandom), $urandom);
			end else begin
				queue_drain();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (txn_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d ticks, %0d writes, %0d reads, %0d unused-code transactions",
			tick_count, write_count, read_count, unused_count);
		$display("checked %0d results; input held off %0d cycles by output backpressure",
			results_seen, in_stall_cycles);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("multi_channel_pwm_generator regression: pass");
		end else begin
			$display("multi_channel_pwm_generator regression: fail");
		end
		$finish;
	end

endmodule
